[hw/rtl/elbd_pkg.sv]
package elbd_pkg;

   localparam int TABLE_DEPTH_DEF = 256;

   localparam int ENTRY_W  = 32;
   localparam int CODE_W   = 9;
   localparam int BASE_W   = 8;
   localparam int LENGTH_W = 9;
   localparam int COUNT_W  = 10;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 10;

   localparam logic signed [31:0] YEAR_HIGH     = 32'sd32767;
   localparam logic signed [31:0] YEAR_LOW      = -32'sd32768;
   localparam logic [31:0]        END_ONLY_MARK = 32'h8000_0101;
   localparam logic [7:0]         MONTH_MAX     = 8'd12;
   localparam logic [7:0]         DAY_MAX       = 8'd31;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ERA_BASE     = 2'd0,
      CSR_TABLE_LENGTH = 2'd1,
      CSR_ERA_COUNT    = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PEEK,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic clr_step;
      logic q_load;
      logic scan_init;
      logic scan_run;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic q_bad;
      logic len_zero;
      logic scan_done;
      logic out_free;
   } dp_status_type;

endpackage

[hw/rtl/elbd_req_if.sv]
interface elbd_req_if;
   logic              valid;
   logic              ready;
   logic              func;
   logic [7:0]        entry_index;
   logic signed [31:0] entry_date;
   logic signed [31:0] year;
   logic [7:0]        month;
   logic [7:0]        day;

   modport source (
      output valid, func, entry_index, entry_date, year, month, day,
      input  ready
   );

   modport sink (
      input  valid, func, entry_index, entry_date, year, month, day,
      output ready
   );
endinterface

[hw/rtl/elbd_rsp_if.sv]
interface elbd_rsp_if;
   logic       valid;
   logic       ready;
   logic [8:0] era_code;
   logic       bad_date;

   modport source (
      output valid, era_code, bad_date,
      input  ready
   );

   modport sink (
      input  valid, era_code, bad_date,
      output ready
   );
endinterface

[hw/rtl/era_lookup_by_date_top.sv]
// channel  dir  transfer moves
// req_     in   func, entry_index, entry_date, year, month, day
// rsp_     out  era_code, bad_date (one per query, none per table write)
// csr_     in   csr_we, csr_index, csr_wdata
//
// Query: the table length in use is capped at TABLE_DEPTH, and the scan stops at the first
// match. One table word is read and compared per cycle through the single RAM read port,
// after a peek at the last entry that picks the scan direction. A bad date or a zero
// length skips the peek and the scan. After reset a clearing pass zeroes the whole table;
// req_ready stays low during it. rsp_ready low holds a finished query until the result
// register frees.
module era_lookup_by_date_top #(
   parameter int TABLE_DEPTH = elbd_pkg::TABLE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   elbd_req_if.sink                          req_chan,
   elbd_rsp_if.source                        rsp_chan,
   input  logic                              csr_we,
   input  logic [elbd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [elbd_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   elbd_pkg::dp_cmd_type    ctrl_cmd;
   elbd_pkg::dp_status_type dp_status;
   logic                    req_fire;

   assign req_fire = req_chan.valid && req_chan.ready;

   elbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_func  (req_chan.func),
      .req_ready (req_chan.ready),
      .status    (dp_status),
      .cmd       (ctrl_cmd)
   );

   elbd_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (ctrl_cmd),
      .status          (dp_status),
      .req_fire        (req_fire),
      .req_func        (req_chan.func),
      .req_entry_index (req_chan.entry_index),
      .req_entry_date  (req_chan.entry_date),
      .req_year        (req_chan.year),
      .req_month       (req_chan.month),
      .req_day         (req_chan.day),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_era_code    (rsp_chan.era_code),
      .rsp_bad_date    (rsp_chan.bad_date)
   );

   a_bad_code_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.bad_date |-> rsp_chan.era_code == '0)
      else $error("bad date result with nonzero era code");

   a_no_accept_clearing: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.clr_step |-> !req_chan.ready)
      else $error("request accepted during table clear");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_chan.func |=> !req_chan.ready)
      else $error("new request taken while query in progress");

   a_out_load_valid: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.out_load |=> rsp_chan.valid)
      else $error("result load did not raise rsp valid");

endmodule

[hw/rtl/elbd_ram.sv]
module elbd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/elbd_ctrl.sv]
module elbd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_func,
   output logic                    req_ready,
   input  elbd_pkg::dp_status_type status,
   output elbd_pkg::dp_cmd_type    cmd
);

   elbd_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= elbd_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         elbd_pkg::ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) begin
               state_in = elbd_pkg::ST_IDLE;
            end
         end
         elbd_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && req_func) begin
               cmd.q_load = 1'b1;
               if (status.q_bad || status.len_zero) begin
                  state_in = elbd_pkg::ST_DONE;
               end else begin
                  state_in = elbd_pkg::ST_PEEK;
               end
            end
         end
         elbd_pkg::ST_PEEK: begin
            cmd.scan_init = 1'b1;
            state_in      = elbd_pkg::ST_SCAN;
         end
         elbd_pkg::ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (status.scan_done) begin
               state_in = elbd_pkg::ST_DONE;
            end
         end
         elbd_pkg::ST_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = elbd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = elbd_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[hw/rtl/elbd_dp.sv]
module elbd_dp #(
   parameter int TABLE_DEPTH = elbd_pkg::TABLE_DEPTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  elbd_pkg::dp_cmd_type                  cmd,
   output elbd_pkg::dp_status_type               status,
   input  logic                                  req_fire,
   input  logic                                  req_func,
   input  logic [7:0]                            req_entry_index,
   input  logic signed [31:0]                    req_entry_date,
   input  logic signed [31:0]                    req_year,
   input  logic [7:0]                            req_month,
   input  logic [7:0]                            req_day,
   input  logic                                  csr_we,
   input  logic [elbd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [elbd_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output logic [elbd_pkg::CODE_W-1:0]           rsp_era_code,
   output logic                                  rsp_bad_date
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int LW = $clog2(TABLE_DEPTH + 1);

   localparam int EW = elbd_pkg::ENTRY_W;
   localparam int CW = elbd_pkg::CODE_W;

   // configuration
   logic [elbd_pkg::BASE_W-1:0]   era_base_ff, era_base_in;
   logic [elbd_pkg::LENGTH_W-1:0] table_length_ff, table_length_in;
   logic [elbd_pkg::COUNT_W-1:0]  era_count_ff, era_count_in;

   // query
   logic                 lo_ff, lo_in;
   logic                 hi_ff, hi_in;
   logic signed [EW-1:0] packed_ff, packed_in;

   // scan
   logic [AW-1:0] clr_ptr_ff, clr_ptr_in;
   logic [AW-1:0] issue_ptr_ff, issue_ptr_in;
   logic [AW-1:0] cmp_idx_ff, cmp_idx_in;
   logic [LW-1:0] left_ff, left_in;
   logic          pend_ff, pend_in;
   logic          rev_ff, rev_in;
   logic [CW-1:0] code_ff, code_in;
   logic          bad_ff, bad_in;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0] rsp_code_ff, rsp_code_in;
   logic          rsp_bad_ff, rsp_bad_in;

   logic [LW-1:0] len;
   logic [AW-1:0] last_idx;
   logic          in_range;
   logic          q_bad;
   logic          match;
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [EW-1:0] ram_wdata;
   logic [AW-1:0] ram_raddr;
   logic [EW-1:0] ram_rdata;

   assign len = (32'(table_length_ff) > 32'(TABLE_DEPTH)) ? LW'(TABLE_DEPTH)
                                                        : LW'(table_length_ff);
   assign last_idx = AW'(len - LW'(1));
   assign in_range = 32'(req_entry_index) < 32'(TABLE_DEPTH);
   assign q_bad = (req_month == 8'd0) || (req_month > elbd_pkg::MONTH_MAX) ||
                  (req_day == 8'd0) || (req_day > elbd_pkg::DAY_MAX);

   assign ram_we    = cmd.clr_step || (req_fire && !req_func && in_range);
   assign ram_waddr = cmd.clr_step ? clr_ptr_ff : AW'(req_entry_index);
   assign ram_wdata = cmd.clr_step ? '0 : req_entry_date;
   assign ram_raddr = cmd.scan_run ? issue_ptr_ff : last_idx;

   elbd_ram #(
      .WIDTH (EW),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      match = 1'b0;
      if (ram_rdata != '0) begin
         if (lo_ff) begin
            match = ram_rdata == elbd_pkg::END_ONLY_MARK;
         end else if (hi_ff) begin
            match = 1'b1;
         end else begin
            match = $signed(ram_rdata) <= packed_ff;
         end
      end
   end

   assign status.clr_last  = clr_ptr_ff == AW'(TABLE_DEPTH - 1);
   assign status.q_bad     = q_bad;
   assign status.len_zero  = len == '0;
   assign status.scan_done = pend_ff && (match || left_ff == '0);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      era_base_in     = era_base_ff;
      table_length_in = table_length_ff;
      era_count_in    = era_count_ff;
      lo_in           = lo_ff;
      hi_in           = hi_ff;
      packed_in       = packed_ff;
      clr_ptr_in      = clr_ptr_ff;
      issue_ptr_in    = issue_ptr_ff;
      cmp_idx_in      = cmp_idx_ff;
      left_in         = left_ff;
      pend_in         = pend_ff;
      rev_in          = rev_ff;
      code_in         = code_ff;
      bad_in          = bad_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_code_in     = rsp_code_ff;
      rsp_bad_in      = rsp_bad_ff;

      if (csr_we) begin
         case (csr_index)
            elbd_pkg::CSR_ERA_BASE:     era_base_in     = csr_wdata[elbd_pkg::BASE_W-1:0];
            elbd_pkg::CSR_TABLE_LENGTH: table_length_in = csr_wdata[elbd_pkg::LENGTH_W-1:0];
            elbd_pkg::CSR_ERA_COUNT:    era_count_in    = csr_wdata[elbd_pkg::COUNT_W-1:0];
            default: begin
            end
         endcase
      end

      if (cmd.clr_step) begin
         clr_ptr_in = clr_ptr_ff + AW'(1);
      end

      if (cmd.q_load) begin
         lo_in     = req_year < elbd_pkg::YEAR_LOW;
         hi_in     = req_year > elbd_pkg::YEAR_HIGH;
         packed_in = {req_year[15:0], req_month, req_day};
         bad_in    = q_bad;
         code_in   = q_bad ? '0 : CW'(era_base_ff);
      end

      // data of the len-1 peek is on ram_rdata here
      if (cmd.scan_init) begin
         rev_in       = (era_count_ff > elbd_pkg::COUNT_W'(1)) &&
                        (ram_rdata == elbd_pkg::END_ONLY_MARK);
         issue_ptr_in = rev_in ? '0 : last_idx;
         left_in      = len;
         pend_in      = 1'b0;
         code_in      = rev_in ? CW'(era_base_ff) + CW'(last_idx) : CW'(era_base_ff);
      end

      if (cmd.scan_run) begin
         if (left_ff != '0) begin
            pend_in      = 1'b1;
            cmp_idx_in   = issue_ptr_ff;
            issue_ptr_in = rev_ff ? issue_ptr_ff + AW'(1) : issue_ptr_ff - AW'(1);
            left_in      = left_ff - LW'(1);
         end else begin
            pend_in = 1'b0;
         end
         if (pend_ff && match) begin
            code_in = CW'(era_base_ff) + CW'(cmp_idx_ff);
         end
      end

      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_code_in  = code_ff;
         rsp_bad_in   = bad_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         era_base_ff     <= '0;
         table_length_ff <= '0;
         era_count_ff    <= '0;
         clr_ptr_ff      <= '0;
         pend_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         era_base_ff     <= era_base_in;
         table_length_ff <= table_length_in;
         era_count_ff    <= era_count_in;
         clr_ptr_ff      <= clr_ptr_in;
         pend_ff         <= pend_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      packed_ff    <= packed_in;
      issue_ptr_ff <= issue_ptr_in;
      cmp_idx_ff   <= cmp_idx_in;
      left_ff      <= left_in;
      rev_ff       <= rev_in;
      code_ff      <= code_in;
      bad_ff       <= bad_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_era_code = rsp_code_ff;
   assign rsp_bad_date = rsp_bad_ff;

endmodule

[sim/era_lookup_by_date_top_test.sv]
`timescale 1ns / 1ps

module era_lookup_by_date_top_test;

   localparam int TABLE_DEPTH  = elbd_pkg::TABLE_DEPTH_DEF;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_ITEMS = 1250;
   localparam int STEADY_OPS   = 150;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;
   localparam logic [elbd_pkg::CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 2'd3;

   typedef struct packed {
      logic [elbd_pkg::CODE_W-1:0] era_code;
      logic                        bad_date;
   } era_result_type;

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             csr_we;
   logic [elbd_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [elbd_pkg::CSR_DATA_W-1:0]  csr_wdata;

   elbd_req_if req_bus ();
   elbd_rsp_if rsp_bus ();

   // mirror of table and registers
   logic [elbd_pkg::ENTRY_W-1:0]  start_mirror [TABLE_DEPTH];
   logic [elbd_pkg::BASE_W-1:0]   base_q;
   logic [elbd_pkg::LENGTH_W-1:0] len_q;
   logic [elbd_pkg::COUNT_W-1:0]  count_q;

   era_result_type era_expect_q [$];

   int error_count    = 0;
   int items_sent     = 0;
   int results_seen   = 0;
   int req_idle_pct   = 0;
   int rsp_idle_pct   = 0;
   int rsp_stall_left = 0;

   era_lookup_by_date_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void note_error(input string msg);
      error_count++;
      if (error_count <= 10)
         $display("%s", msg);
   endfunction

   function automatic logic [elbd_pkg::ENTRY_W-1:0] pack_date(input int y, input int m,
                                                              input int d);
      return {y[15:0], m[7:0], d[7:0]};
   endfunction

   function automatic bit starts_by(input logic [elbd_pkg::ENTRY_W-1:0] s,
                                    input logic signed [31:0] yr,
                                    input logic [7:0] mo, input logic [7:0] dy);
      if (yr < elbd_pkg::YEAR_LOW)
         return s == elbd_pkg::END_ONLY_MARK;
      if (yr > elbd_pkg::YEAR_HIGH)
         return 1'b1;
      return $signed(s) <= $signed({yr[15:0], mo, dy});
   endfunction

   function automatic era_result_type era_for_date(input logic signed [31:0] yr,
                                                   input logic [7:0] mo,
                                                   input logic [7:0] dy);
      era_result_type r;
      int span;
      r.era_code = '0;
      r.bad_date = 1'b0;
      if (mo < 1 || mo > elbd_pkg::MONTH_MAX || dy < 1 || dy > elbd_pkg::DAY_MAX) begin
         r.bad_date = 1'b1;
         return r;
      end
      span = (len_q > TABLE_DEPTH) ? TABLE_DEPTH : int'(len_q);
      r.era_code = elbd_pkg::CODE_W'(base_q);
      if (count_q > 1 && span > 0 && start_mirror[span-1] == elbd_pkg::END_ONLY_MARK) begin
         // reverse-ordered table: forward scan, default to last slot
         r.era_code = elbd_pkg::CODE_W'(base_q) + elbd_pkg::CODE_W'(span - 1);
         for (int i = 0; i < span; i++) begin
            if (start_mirror[i] != '0 && starts_by(start_mirror[i], yr, mo, dy)) begin
               r.era_code = elbd_pkg::CODE_W'(base_q) + elbd_pkg::CODE_W'(i);
               break;
            end
         end
      end else begin
         for (int i = span - 1; i >= 0; i--) begin
            if (start_mirror[i] != '0 && starts_by(start_mirror[i], yr, mo, dy)) begin
               r.era_code = elbd_pkg::CODE_W'(base_q) + elbd_pkg::CODE_W'(i);
               break;
            end
         end
      end
      return r;
   endfunction

   // one transfer on the request channel, with an optional idle burst ahead of it
   task automatic send_item(input logic f, input logic [7:0] idx, input logic [31:0] entry,
                            input logic signed [31:0] yr, input logic [7:0] mo,
                            input logic [7:0] dy);
      if ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(16, 1)) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.func        <= f;
      req_bus.entry_index <= idx;
      req_bus.entry_date  <= entry;
      req_bus.year        <= yr;
      req_bus.month       <= mo;
      req_bus.day         <= dy;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      items_sent++;
      if (f == FUNC_WRITE) begin
         if (idx < TABLE_DEPTH)
            start_mirror[idx] = entry;
      end else begin
         era_expect_q.push_back(era_for_date(yr, mo, dy));
      end
   endtask

   task automatic put_entry(input logic [7:0] idx, input logic [31:0] entry);
      send_item(FUNC_WRITE, idx, entry, $urandom, 8'($urandom), 8'($urandom));
   endtask

   task automatic ask_era(input logic signed [31:0] yr, input logic [7:0] mo,
                          input logic [7:0] dy);
      send_item(FUNC_QUERY, 8'($urandom), $urandom, yr, mo, dy);
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (era_expect_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [elbd_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [elbd_pkg::CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         elbd_pkg::CSR_ERA_BASE:     base_q = value[elbd_pkg::BASE_W-1:0];
         elbd_pkg::CSR_TABLE_LENGTH: len_q = value[elbd_pkg::LENGTH_W-1:0];
         elbd_pkg::CSR_ERA_COUNT:    count_q = value[elbd_pkg::COUNT_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic configure(input logic [elbd_pkg::BASE_W-1:0] base,
                            input logic [elbd_pkg::LENGTH_W-1:0] len,
                            input logic [elbd_pkg::COUNT_W-1:0] count);
      wait_idle();
      write_reg(elbd_pkg::CSR_ERA_BASE, {2'($urandom), base});
      write_reg(elbd_pkg::CSR_TABLE_LENGTH, {1'($urandom), len});
      write_reg(elbd_pkg::CSR_ERA_COUNT, count);
   endtask

   task automatic fill_table(input int span, input bit mark_last);
      int y;
      int step;
      bit rising;
      logic [31:0] entry;
      rising = 1'($urandom_range(1));
      y = int'($urandom_range(2000)) - 500;
      if (!rising)
         y = y + 2000;
      if ($urandom_range(3) == 0)
         y = rising ? -32768 : 32767;
      for (int i = 0; i < span; i++) begin
         if (mark_last && i == span - 1)
            entry = elbd_pkg::END_ONLY_MARK;
         else if ($urandom_range(9) == 0)
            entry = '0;
         else
            entry = pack_date(y, $urandom_range(1, 12), $urandom_range(1, 31));
         put_entry(8'(i), entry);
         step = $urandom_range(40);
         y = rising ? y + step : y - step;
      end
   endtask

   task automatic ask_near_entry(input int span);
      int k;
      int y;
      logic [31:0] s;
      if (span == 0) begin
         ask_era(int'($urandom_range(4000)) - 2000, 8'($urandom_range(1, 12)),
                 8'($urandom_range(1, 31)));
         return;
      end
      k = $urandom_range(span - 1);
      s = start_mirror[k];
      if (s == '0 || s == elbd_pkg::END_ONLY_MARK)
         y = int'($urandom_range(4000)) - 2000;
      else
         y = int'($signed(s[31:16]));
      if (s != '0 && s != elbd_pkg::END_ONLY_MARK && $urandom_range(2) == 0)
         ask_era(y, s[15:8], s[7:0]);
      else
         ask_era(y + int'($urandom_range(4)) - 2, 8'($urandom_range(1, 12)),
                 8'($urandom_range(1, 31)));
   endtask

   task automatic random_op(input int span, input bit allow_pause);
      int pick;
      logic signed [31:0] y;
      pick = $urandom_range(allow_pause ? 99 : 94);
      if (pick < 55) begin
         ask_near_entry(span);
      end else if (pick < 65) begin
         case ($urandom_range(6))
            0: y = 32'sh8000_0000;
            1: y = 32'sh7fff_ffff;
            2: y = -32769;
            3: y = -32768;
            4: y = 32767;
            5: y = 32768;
            default: y = $urandom;
         endcase
         ask_era(y, 8'($urandom_range(1, 12)), 8'($urandom_range(1, 31)));
      end else if (pick < 73) begin
         if ($urandom_range(1))
            ask_era($urandom, 8'($urandom_range(1) ? 0 : $urandom_range(255, 13)),
                    8'($urandom_range(1, 31)));
         else
            ask_era($urandom, 8'($urandom_range(1, 12)),
                    8'($urandom_range(1) ? 0 : $urandom_range(255, 32)));
      end else if (pick < 83) begin
         put_entry(8'(span != 0 ? $urandom_range(span - 1) : $urandom), $urandom);
      end else if (pick < 95) begin
         ask_era($urandom, 8'($urandom), 8'($urandom));
      end else begin
         wait_idle();
      end
   endtask

   task automatic test_reset_defaults();
      req_idle_pct = 20;
      rsp_idle_pct = 20;
      ask_era(2000, 1, 1);
      ask_era(0, 0, 0);
   endtask

   task automatic test_directed_cases();
      configure(8'hff, 4, 0);
      write_reg(CSR_UNUSED_INDEX, 10'h3ff);
      put_entry(0, pack_date(1868, 9, 8));
      put_entry(1, '0);
      put_entry(2, pack_date(1989, 1, 8));
      put_entry(3, pack_date(2019, 5, 1));
      ask_era(2019, 5, 1);
      ask_era(2019, 4, 30);
      ask_era(1900, 1, 1);
      ask_era(1800, 1, 1);
      ask_era(2000, 0, 1);
      ask_era(2000, 13, 1);
      ask_era(2000, 1, 0);
      ask_era(2000, 1, 32);
      ask_era(2000, 8'hff, 8'hff);
      ask_era(32'sh8000_0000, 1, 1);
      ask_era(32'sh7fff_ffff, 12, 31);
      ask_era(-32769, 6, 15);
      ask_era(32768, 1, 1);
      ask_era(32767, 12, 31);
      ask_era(-32768, 1, 1);
      // end-only era in last slot flips the scan direction
      configure(8'hff, 5, 2);
      put_entry(4, elbd_pkg::END_ONLY_MARK);
      ask_era(-32769, 1, 1);
      ask_era(2000, 1, 1);
      ask_era(-32768, 1, 1);
      // length past the table depth is clamped
      configure(8'd7, 9'd300, 10'h3ff);
      ask_era(2020, 1, 1);
   endtask

   task automatic test_random_phases(input int target);
      int phase;
      int span;
      bit mark_last;
      logic [elbd_pkg::BASE_W-1:0]   base;
      logic [elbd_pkg::LENGTH_W-1:0] len;
      logic [elbd_pkg::COUNT_W-1:0]  count;
      phase = 0;
      while (items_sent < target) begin
         if (phase == 0) begin
            base = '0;
            len = 9'd256;
            count = '0;
         end else if (phase == 1) begin
            base = 8'hff;
            len = 9'h1ff;
            count = 10'h3ff;
         end else if (phase == 2) begin
            base = 8'($urandom);
            len = '0;
            count = 10'd2;
         end else begin
            base = $urandom_range(3) == 0 ? ($urandom_range(1) ? 8'h00 : 8'hff) : 8'($urandom);
            len = $urandom_range(15) == 0 ? 9'($urandom_range(511, 17)) : 9'($urandom_range(16));
            case ($urandom_range(4))
               0: count = '0;
               1: count = 10'd1;
               2: count = 10'd2;
               3: count = 10'h3ff;
               default: count = 10'($urandom);
            endcase
         end
         case ($urandom_range(3))
            0: req_idle_pct = 0;
            1: req_idle_pct = 10;
            2: req_idle_pct = 30;
            default: req_idle_pct = 60;
         endcase
         case ($urandom_range(3))
            0: rsp_idle_pct = 0;
            1: rsp_idle_pct = 10;
            2: rsp_idle_pct = 30;
            default: rsp_idle_pct = 60;
         endcase
         mark_last = count > 1 && $urandom_range(1);
         configure(base, len, count);
         span = (len > TABLE_DEPTH) ? TABLE_DEPTH : int'(len);
         if (phase == 1)
            put_entry(8'(TABLE_DEPTH - 1), elbd_pkg::END_ONLY_MARK);
         else if (span != 0 && !(span == TABLE_DEPTH && phase > 2))
            fill_table(span, mark_last);
         repeat ($urandom_range(40, 10)) random_op(span, 1'b1);
         phase++;
      end
   endtask

   task automatic test_steady_flow();
      int span;
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      span = $urandom_range(16, 1);
      configure(8'($urandom), 9'(span), 10'($urandom_range(3)));
      fill_table(span, 1'($urandom_range(1)));
      repeat (STEADY_OPS) random_op(span, 1'b0);
   endtask

   always @(posedge clock) begin
      era_result_type want;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (era_expect_q.size() == 0) begin
               note_error($sformatf("result %0d unexpected: era_code %0d bad_date %0b",
                                    results_seen, rsp_bus.era_code, rsp_bus.bad_date));
            end else begin
               want = era_expect_q.pop_front();
               if (rsp_bus.era_code !== want.era_code || rsp_bus.bad_date !== want.bad_date)
                  note_error($sformatf(
                     "result %0d: era_code exp %0d act %0d, bad_date exp %0b act %0b",
                     results_seen, want.era_code, rsp_bus.era_code,
                     want.bad_date, rsp_bus.bad_date));
            end
         end
         if (rsp_stall_left > 0) begin
            rsp_stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if ($urandom_range(99) < rsp_idle_pct) begin
            rsp_stall_left = $urandom_range(15);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = '0;
      csr_wdata           = '0;
      req_bus.valid       = 1'b0;
      req_bus.func        = FUNC_WRITE;
      req_bus.entry_index = '0;
      req_bus.entry_date  = '0;
      req_bus.year        = '0;
      req_bus.month       = '0;
      req_bus.day         = '0;
      rsp_bus.ready       = 1'b0;
      for (int i = 0; i < TABLE_DEPTH; i++)
         start_mirror[i] = '0;
      base_q  = '0;
      len_q   = '0;
      count_q = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      // table clear runs after reset
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      test_reset_defaults();
      test_directed_cases();
      test_random_phases(RANDOM_ITEMS);
      test_steady_flow();
      req_bus.valid <= 1'b0;
      while (era_expect_q.size() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);
      if (error_count == 0 && era_expect_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
